// ===== hw/rtl/eds_pkg.sv =====
// Shared types and constants for the streaming edit distance block.
`default_nettype none

package eds_pkg;

    localparam int REG_CHARS  = 32;   // pattern characters the registers hold
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_W      = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH,
        CFG_CHARS_A,
        CFG_CHARS_B,
        CFG_CHARS_C,
        CFG_CHARS_D
    } eds_cfg_t;

    // token that travels down the cell row with each character
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              empty;
        logic [CHAR_W-1:0] text;
    } eds_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/edit_distance_stream.sv =====
// Top level of the streaming edit distance block: registers, cell row, result register.
//
//  channel  | direction | tdata / data          | side band
//  ---------+-----------+-----------------------+---------------------------
//  s_axis   | in        | [7:0] text_char       | tlast last_char, tuser empty_word
//  m_axis   | out       | [7:0] distance        | tuser saturated
//  cfg      | in        | cfg_data, cfg_index   | index 0 length, 1..4 chars
//
//  One character request per cycle while the row is not stalled; the result of a word is
//  picked off at cell L, L being the pattern length clamped to the cell count.
//  Each character moves one cell per cycle down the row (skewed wavefront) unless the row stalls.
//  The row stalls only when a result is due while the result register is full and m_axis_tready is low.
//  Reset puts the column into its start values at once; no clearing pass.
`default_nettype none

module edit_distance_stream #(
    parameter int MAX_PATTERN = 32,
    parameter int COST_WIDTH  = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] text_char
    input  wire logic                           s_axis_tlast,
    input  wire logic                           s_axis_tuser,  // [0] empty_word
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // [7:0] distance
    output logic                                m_axis_tuser,  // [0] saturated
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [eds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [eds_pkg::CFG_DATA_W-1:0] cfg_data
);
    import eds_pkg::*;

    localparam int CELLS = (MAX_PATTERN < REG_CHARS) ? MAX_PATTERN : REG_CHARS;
    localparam int LW    = $clog2(CELLS + 1);
    localparam int CW    = COST_WIDTH + 1;
    localparam logic [COST_WIDTH-1:0] COST_MAX = '1;

    logic [LEN_W-1:0]      length_reg;
    logic [CFG_DATA_W-1:0] chars_reg [4];
    logic [LW-1:0]         len_used;

    eds_ctl_t      ctl_link  [CELLS+1];
    logic [CW-1:0] diag_link [CELLS+1];
    logic [CW-1:0] left_link [CELLS+1];

    logic                  en, emit;
    eds_ctl_t              emit_ctl;
    logic [CW-1:0]         emit_val;
    logic                  out_valid_reg, out_valid_next;
    logic [COST_WIDTH-1:0] dist_reg;
    logic                  sat_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            for (int k = 0; k < 4; k++)
            begin
                chars_reg[k] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LENGTH:  length_reg   <= cfg_data[LEN_W-1:0];
                CFG_CHARS_A: chars_reg[0] <= cfg_data;
                CFG_CHARS_B: chars_reg[1] <= cfg_data;
                CFG_CHARS_C: chars_reg[2] <= cfg_data;
                CFG_CHARS_D: chars_reg[3] <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign len_used = (32'(length_reg) > CELLS) ? LW'(CELLS) : LW'(length_reg);

    // cell row
    assign s_axis_tready = en;

    eds_head #(
        .COST_WIDTH (COST_WIDTH)
    ) u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .take     (s_axis_tvalid && en),
        .in_text  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .in_empty (s_axis_tuser),
        .ctl_out  (ctl_link[0]),
        .diag_out (diag_link[0]),
        .left_out (left_link[0])
    );

    for (genvar j = 1; j <= CELLS; j++)
    begin : g_cell
        localparam int WSEL = (j - 1) / 8;
        localparam int BSEL = ((j - 1) % 8) * 8;

        eds_cell #(
            .CELL_INDEX (j),
            .COST_WIDTH (COST_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .pat_char (chars_reg[WSEL][BSEL +: CHAR_W]),
            .ctl_in   (ctl_link[j-1]),
            .diag_in  (diag_link[j-1]),
            .left_in  (left_link[j-1]),
            .ctl_out  (ctl_link[j]),
            .diag_out (diag_link[j]),
            .left_out (left_link[j])
        );
    end

    // result pick-off at the cell selected by the pattern length
    assign emit_ctl = ctl_link[len_used];
    assign emit_val = left_link[len_used];
    assign emit     = emit_ctl.valid && (emit_ctl.last || emit_ctl.empty);
    assign en       = !(emit && out_valid_reg && !m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit && en)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && en)
        begin
            sat_reg  <= emit_val[COST_WIDTH];
            dist_reg <= emit_val[COST_WIDTH] ? COST_MAX : emit_val[COST_WIDTH-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 8'(dist_reg);
    assign m_axis_tuser  = sat_reg;

    // a waiting result stays until taken
    a_hold_result : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg)
        else $error("result dropped before it was taken");

    // an empty-word request enters the row as an empty token
    a_empty_token : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> ctl_link[0].valid && ctl_link[0].empty)
        else $error("empty-word token lost at row entry");

    // a result picked off the row shows up on the output next cycle
    a_emit_shown : assert property (@(posedge clk) disable iff (!rst_n)
        emit && en |=> m_axis_tvalid)
        else $error("emitted result not presented");

endmodule

`default_nettype wire

// ===== hw/rtl/eds_head.sv =====
// Head cell: takes the input request and keeps the word position (column entry 0).
`default_nettype none

module eds_head #(
    parameter int COST_WIDTH = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       take,
    input  wire logic [eds_pkg::CHAR_W-1:0] in_text,
    input  wire logic                       in_last,
    input  wire logic                       in_empty,
    output eds_pkg::eds_ctl_t               ctl_out,
    output logic [COST_WIDTH:0]             diag_out,
    output logic [COST_WIDTH:0]             left_out
);
    import eds_pkg::*;

    localparam int CW = COST_WIDTH + 1;
    localparam logic [CW-1:0] CAP = CW'(1) << COST_WIDTH;

    logic [CW-1:0] wp_reg, wp_next;
    logic [CW-1:0] diag_reg, diag_next;
    logic [CW-1:0] left_reg, left_next;
    eds_ctl_t      ctl_reg, ctl_next;
    logic [CW-1:0] wp_inc;

    always_comb
    begin
        wp_inc    = (wp_reg >= CAP) ? CAP : wp_reg + CW'(1);
        wp_next   = wp_reg;
        diag_next = wp_reg;
        left_next = wp_inc;
        ctl_next  = '{valid: take, last: in_last, empty: in_empty, text: in_text};
        if (take)
        begin
            if (in_empty)
            begin
                wp_next   = '0;
                left_next = '0;
            end
            else if (in_last)
            begin
                wp_next = '0;
            end
            else
            begin
                wp_next = wp_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            wp_reg  <= wp_next;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diag_reg <= diag_next;
            left_reg <= left_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign diag_out = diag_reg;
    assign left_out = left_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/eds_cell.sv =====
// Pattern cell: holds one column entry and updates it for each passing character.
`default_nettype none

module eds_cell #(
    parameter int CELL_INDEX = 1,
    parameter int COST_WIDTH = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic [eds_pkg::CHAR_W-1:0] pat_char,
    input  wire eds_pkg::eds_ctl_t          ctl_in,
    input  wire logic [COST_WIDTH:0]        diag_in,
    input  wire logic [COST_WIDTH:0]        left_in,
    output eds_pkg::eds_ctl_t               ctl_out,
    output logic [COST_WIDTH:0]             diag_out,
    output logic [COST_WIDTH:0]             left_out
);
    import eds_pkg::*;

    localparam int CW = COST_WIDTH + 1;
    localparam int CAP_I = 1 << COST_WIDTH;
    localparam logic [CW-1:0] CAP = CW'(CAP_I);
    localparam logic [CW-1:0] RST_VAL = CW'((CELL_INDEX < CAP_I) ? CELL_INDEX : CAP_I);

    logic [CW-1:0] val_reg, val_next;
    logic [CW-1:0] diag_reg, diag_next;
    logic [CW-1:0] left_reg, left_next;
    eds_ctl_t      ctl_reg;
    logic [CW-1:0] min_du, best, best_inc, cost;

    always_comb
    begin
        min_du   = (diag_in < val_reg) ? diag_in : val_reg;
        best     = (left_in < min_du) ? left_in : min_du;
        best_inc = (best >= CAP) ? CAP : best + CW'(1);
        cost     = (pat_char == ctl_in.text) ? diag_in : best_inc;

        val_next  = val_reg;
        diag_next = val_reg;
        left_next = cost;
        if (ctl_in.valid)
        begin
            if (ctl_in.empty)
            begin
                val_next  = RST_VAL;
                left_next = RST_VAL;
            end
            else if (ctl_in.last)
            begin
                val_next = RST_VAL;
            end
            else
            begin
                val_next = cost;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= RST_VAL;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            val_reg <= val_next;
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diag_reg <= diag_next;
            left_reg <= left_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign diag_out = diag_reg;
    assign left_out = left_reg;

endmodule

`default_nettype wire
